>>> design/timeout_slot_bank_unit_defines.svh
// assertion macros for the timeout slot bank
// used by the top level, expects clk and arst_n in scope
`ifndef TIMEOUT_SLOT_BANK_UNIT_DEFINES_SVH
`define TIMEOUT_SLOT_BANK_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define TSB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timeout slot bank check failed");

// condition implies consequence in the next cycle
`define TSB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timeout slot bank check failed");

`endif

>>> design/tsb_pkg.sv
// shared types and codes for the timeout slot bank
// no dependencies
`default_nettype none

package tsb_pkg;

	localparam int KEY_W = 8;
	localparam int CNT_W = 32;
	localparam int ENT_W = KEY_W + CNT_W;

	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_ADD    = 2'd1,
		FN_REMOVE = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOSPACE  = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_APPLY,
		S_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic walk;
		logic apply;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> design/tsb_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module tsb_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/tsb_ctrl.sv
// controller for the timeout slot bank: sequences accept, slot walk, update, result
// depends on tsb_pkg
`default_nettype none

module tsb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tsb_pkg::sts_t sts,
	output tsb_pkg::cmd_t      cmd
);

	tsb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tsb_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = tsb_pkg::S_WALK;
				end
			end
			tsb_pkg::S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_last) begin
					state_d = tsb_pkg::S_DRAIN;
				end
			end
			tsb_pkg::S_DRAIN: begin
				state_d = tsb_pkg::S_APPLY;
			end
			tsb_pkg::S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = tsb_pkg::S_DONE;
			end
			tsb_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = tsb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tsb_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/tsb_dp.sv
// datapath for the timeout slot bank: slot ram, valid bits, search, counter, output register
// depends on tsb_pkg and tsb_ram
`default_nettype none

module tsb_dp #(
	parameter int SLOTS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tsb_pkg::cmd_t              cmd,
	output tsb_pkg::sts_t                   sts,
	input  wire logic [1:0]                 func,
	input  wire logic [tsb_pkg::KEY_W-1:0]  timer_id,
	input  wire logic [tsb_pkg::CNT_W-1:0]  timeout_value,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [1:0]                      status,
	output logic [tsb_pkg::CNT_W-1:0]       remaining,
	output logic [tsb_pkg::CNT_W-1:0]       ms_now
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	tsb_pkg::func_t                func_q;
	logic [tsb_pkg::KEY_W-1:0]     id_q;
	logic [tsb_pkg::CNT_W-1:0]     tval_q;
	logic [IW-1:0]                 addr_q;
	logic                          chk_vld_s1;
	logic [IW-1:0]                 chk_idx_s1;
	logic [SLOTS-1:0]              valid_q;
	logic                          match_q;
	logic [IW-1:0]                 match_idx_q;
	logic                          empty_q;
	logic [IW-1:0]                 empty_idx_q;
	logic [tsb_pkg::CNT_W-1:0]     rem_q;
	logic [tsb_pkg::CNT_W-1:0]     ms_q;
	logic                          out_valid_q;
	logic [1:0]                    status_q;
	logic [tsb_pkg::CNT_W-1:0]     remaining_q;
	logic [tsb_pkg::CNT_W-1:0]     ms_now_q;

	logic                          ram_we;
	logic [IW-1:0]                 ram_waddr;
	logic [tsb_pkg::ENT_W-1:0]     ram_wdata;
	logic [tsb_pkg::ENT_W-1:0]     ram_rdata;
	logic [tsb_pkg::KEY_W-1:0]     rd_key;
	logic [tsb_pkg::CNT_W-1:0]     rd_cnt;
	logic                          slot_vld;
	logic                          hit;
	logic [1:0]                    status_d;

	tsb_ram #(
		.WIDTH(tsb_pkg::ENT_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.walk),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	assign rd_key   = ram_rdata[tsb_pkg::ENT_W-1:tsb_pkg::CNT_W];
	assign rd_cnt   = ram_rdata[tsb_pkg::CNT_W-1:0];
	assign slot_vld = valid_q[chk_idx_s1];
	assign hit      = chk_vld_s1 && slot_vld && (rd_key == id_q);

	assign sts.walk_last = (addr_q == IW'(SLOTS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	// add update after the walk, tick decrement during it
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_idx_s1;
		ram_wdata = {rd_key, rd_cnt - tsb_pkg::CNT_W'(1)};
		if (cmd.apply && func_q == tsb_pkg::FN_ADD) begin
			ram_wdata = {id_q, tval_q};
			if (match_q) begin
				ram_we    = 1'b1;
				ram_waddr = match_idx_q;
			end else if (empty_q) begin
				ram_we    = 1'b1;
				ram_waddr = empty_idx_q;
			end
		end else if (chk_vld_s1 && func_q == tsb_pkg::FN_TICK && slot_vld
				&& rd_cnt != '0) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		status_d = tsb_pkg::ST_OK;
		case (func_q)
			tsb_pkg::FN_ADD: begin
				if (!match_q && !empty_q) begin
					status_d = tsb_pkg::ST_NOSPACE;
				end
			end
			tsb_pkg::FN_REMOVE, tsb_pkg::FN_READ: begin
				if (!match_q) begin
					status_d = tsb_pkg::ST_NOTFOUND;
				end
			end
			default: begin
				status_d = tsb_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q <= tsb_pkg::func_t'(func);
			id_q   <= timer_id;
			tval_q <= timeout_value;
		end
		chk_idx_s1 <= addr_q;
		if (hit) begin
			match_idx_q <= chk_idx_s1;
			rem_q       <= rd_cnt;
		end
		if (chk_vld_s1 && !slot_vld && !empty_q) begin
			empty_idx_q <= chk_idx_s1;
		end
		if (cmd.load) begin
			status_q    <= status_d;
			remaining_q <= (func_q == tsb_pkg::FN_READ && match_q) ? rem_q : '0;
			ms_now_q    <= ms_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			chk_vld_s1  <= 1'b0;
			valid_q     <= '0;
			match_q     <= 1'b0;
			empty_q     <= 1'b0;
			ms_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			chk_vld_s1 <= cmd.walk;
			if (cmd.start) begin
				addr_q  <= '0;
				match_q <= 1'b0;
				empty_q <= 1'b0;
				if (func == tsb_pkg::FN_TICK) begin
					ms_q <= ms_q + tsb_pkg::CNT_W'(1);
				end
			end else if (cmd.walk && !sts.walk_last) begin
				addr_q <= addr_q + IW'(1);
			end
			if (hit) begin
				match_q <= 1'b1;
				if (func_q == tsb_pkg::FN_REMOVE) begin
					valid_q[chk_idx_s1] <= 1'b0;
				end
			end
			if (chk_vld_s1 && !slot_vld) begin
				empty_q <= 1'b1;
			end
			if (cmd.apply && func_q == tsb_pkg::FN_ADD && !match_q && empty_q) begin
				valid_q[empty_idx_q] <= 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign remaining = remaining_q;
	assign ms_now    = ms_now_q;

endmodule

`default_nettype wire

>>> design/timeout_slot_bank_unit.sv
// Timeout slot bank: SLOTS countdown timers keyed by an 8-bit id plus a wrapping
// 32-bit millisecond counter. Each item (tick, add, remove, read) passes from
// acceptance to a loaded result through an accept step, a walk over the slot RAM
// at one slot per cycle through its single registered read port, a drain step for
// the last read, an update step and a result step. A result sits in an output
// register, so the next item is taken while it waits. Valid bits live in
// flip-flops cleared by reset; no clearing pass is needed.
// depends on tsb_pkg, tsb_ctrl, tsb_dp and the defines header
`default_nettype none
`include "timeout_slot_bank_unit_defines.svh"

module timeout_slot_bank_unit #(
	parameter int SLOTS = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                func,
	input  wire logic [tsb_pkg::KEY_W-1:0] timer_id,
	input  wire logic [tsb_pkg::CNT_W-1:0] timeout_value,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [1:0]                     status,
	output logic [tsb_pkg::CNT_W-1:0]      remaining,
	output logic [tsb_pkg::CNT_W-1:0]      ms_now
);

	tsb_pkg::cmd_t cmd;
	tsb_pkg::sts_t sts;

	tsb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tsb_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.timer_id     (timer_id),
		.timeout_value(timeout_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.remaining    (remaining),
		.ms_now       (ms_now)
	);

	`TSB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`TSB_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.start, cmd.walk, cmd.apply, cmd.load}))
	`TSB_ASSERT_IMPL(a_rem_zero_on_fail, out_valid && status != tsb_pkg::ST_OK, remaining == '0)
	`TSB_ASSERT_NEXT(a_load_sets_valid, cmd.load, out_valid)

endmodule

`default_nettype wire
